FILE: rtl/ofe_pkg.sv
// ofe_pkg: shared types and constants for the outbound frame encapsulator.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ofe_pkg;

    localparam int MAX_BYTES = 11;
    localparam int CNT_W     = 4;
    localparam int LEN_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRANSPORT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TCP_FORMAT     = 1'b1;

    localparam logic [7:0] WS_FIN_TEXT   = 8'h81;
    localparam logic [7:0] WS_LEN16_CODE = 8'd126;
    localparam logic [7:0] WS_LEN64_CODE = 8'd127;
    localparam logic [LEN_W-1:0] WS_LEN7_MAX = 32'd125;
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [CNT_W-1:0] HDR_N_NONE  = 4'd0;
    localparam logic [CNT_W-1:0] HDR_N_SHORT = 4'd2;
    localparam logic [CNT_W-1:0] HDR_N_MID   = 4'd4;
    localparam logic [CNT_W-1:0] HDR_N_LONG  = 4'd10;

    typedef logic [MAX_BYTES-1:0][7:0] burst_bytes_t;

    typedef struct packed {
        logic              start_req;
        logic [LEN_W-1:0]  payload_len;
        logic              has_byte;
        logic [7:0]        data_byte;
        logic              last;
    } item_t;

    typedef struct packed {
        burst_bytes_t      bytes;
        logic [CNT_W-1:0]  cnt;
    } burst_t;

    typedef struct packed {
        logic transport_mode;
        logic tcp_format;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ofe_if.sv
// ofe_if: valid/ready channel interfaces for items, results and config writes.
// Depends on ofe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ofe_item_if;
    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [ofe_pkg::LEN_W-1:0]   payload_len;
    logic                        has_byte;
    logic [7:0]                  data_byte;
    logic                        last;

    modport source (output valid, start_req, payload_len, has_byte, data_byte, last,
                    input ready);
    modport sink   (input valid, start_req, payload_len, has_byte, data_byte, last,
                    output ready);
endinterface

interface ofe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface ofe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ofe_pkg::CFG_IDX_W-1:0]   index;
    logic [ofe_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ofe_cfg_regs.sv
// ofe_cfg_regs: transport_mode and tcp_format configuration registers.
// Depends on ofe_pkg and ofe_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module ofe_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ofe_cfg_if.sink      cfg,
    output ofe_pkg::cfg_t cfg_state
);

    ofe_pkg::cfg_t cfg_reg;
    ofe_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                ofe_pkg::CFG_IDX_TRANSPORT_MODE: cfg_next.transport_mode = cfg.data[0];
                ofe_pkg::CFG_IDX_TCP_FORMAT:     cfg_next.tcp_format     = cfg.data[0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg_state = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/ofe_frame_builder.sv
// ofe_frame_builder: input register and the logic that lays out the bytes
// (header, payload byte, CR LF) caused by one item. Depends on ofe_pkg, ofe_item_if.
`timescale 1ns / 1ps
`default_nettype none

module ofe_frame_builder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ofe_item_if.sink           item,
    input  wire ofe_pkg::cfg_t cfg_state,
    input  wire logic          burst_free,
    output logic               load_valid,
    output ofe_pkg::burst_t    load_burst
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    ofe_pkg::item_t s1_item_reg;
    ofe_pkg::item_t s1_item_next;
    logic           accept;

    ofe_pkg::burst_bytes_t      hdr;
    logic [ofe_pkg::CNT_W-1:0]  hdr_n;
    logic [ofe_pkg::CNT_W-1:0]  crlf_pos;
    logic                       add_crlf;
    logic [15:0]                prefix;
    logic [ofe_pkg::LEN_W-1:0]  len;

    assign item.ready = !s1_valid_reg || burst_free;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        s1_item_next = s1_item_reg;
        if (accept)
        begin
            s1_item_next.start_req   = item.start_req;
            s1_item_next.payload_len = item.payload_len;
            s1_item_next.has_byte    = item.has_byte;
            s1_item_next.data_byte   = item.data_byte;
            s1_item_next.last        = item.last;
        end
        if (accept)
            s1_valid_next = 1'b1;
        else if (burst_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    // header layout, left-justified in hdr
    assign len    = s1_item_reg.payload_len;
    assign prefix = len[15:0] + 16'd2;

    always_comb
    begin
        hdr   = '0;
        hdr_n = ofe_pkg::HDR_N_NONE;
        if (s1_item_reg.start_req)
        begin
            if (cfg_state.transport_mode)
            begin
                hdr[0] = ofe_pkg::WS_FIN_TEXT;
                if (len <= ofe_pkg::WS_LEN7_MAX)
                begin
                    hdr[1] = len[7:0];
                    hdr_n  = ofe_pkg::HDR_N_SHORT;
                end
                else if (len[31:16] == 16'd0)
                begin
                    hdr[1] = ofe_pkg::WS_LEN16_CODE;
                    hdr[2] = len[15:8];
                    hdr[3] = len[7:0];
                    hdr_n  = ofe_pkg::HDR_N_MID;
                end
                else
                begin
                    hdr[1] = ofe_pkg::WS_LEN64_CODE;
                    hdr[6] = len[31:24];
                    hdr[7] = len[23:16];
                    hdr[8] = len[15:8];
                    hdr[9] = len[7:0];
                    hdr_n  = ofe_pkg::HDR_N_LONG;
                end
            end
            else if (!cfg_state.tcp_format)
            begin
                hdr[0] = prefix[7:0];
                hdr[1] = prefix[15:8];
                hdr_n  = ofe_pkg::HDR_N_SHORT;
            end
        end
    end

    assign add_crlf = s1_item_reg.last && !cfg_state.transport_mode && cfg_state.tcp_format;
    assign crlf_pos = hdr_n + {{(ofe_pkg::CNT_W-1){1'b0}}, s1_item_reg.has_byte};

    always_comb
    begin
        for (int k = 0; k < ofe_pkg::MAX_BYTES; k++)
        begin
            if (ofe_pkg::CNT_W'(k) < hdr_n)
                load_burst.bytes[k] = hdr[k];
            else if (s1_item_reg.has_byte && ofe_pkg::CNT_W'(k) == hdr_n)
                load_burst.bytes[k] = s1_item_reg.data_byte;
            else if (ofe_pkg::CNT_W'(k) == crlf_pos)
                load_burst.bytes[k] = ofe_pkg::CHAR_CR;
            else
                load_burst.bytes[k] = ofe_pkg::CHAR_LF;
        end
        load_burst.cnt = crlf_pos + (add_crlf ? ofe_pkg::CNT_W'(2) : ofe_pkg::CNT_W'(0));
    end

    assign load_valid = s1_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/ofe_byte_emitter.sv
// ofe_byte_emitter: holds one item's byte burst and shifts it out through
// the result register, one byte per transaction. Depends on ofe_pkg, ofe_result_if.
`timescale 1ns / 1ps
`default_nettype none

module ofe_byte_emitter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load_valid,
    input  wire ofe_pkg::burst_t load_burst,
    output logic                 burst_free,
    ofe_result_if.source         result
);

    logic                       burst_valid_reg;
    logic                       burst_valid_next;
    ofe_pkg::burst_bytes_t      bytes_reg;
    ofe_pkg::burst_bytes_t      bytes_next;
    logic [ofe_pkg::CNT_W-1:0]  cnt_reg;
    logic [ofe_pkg::CNT_W-1:0]  cnt_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 out_byte_reg;
    logic [7:0]                 out_byte_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic out_ok;
    logic emit;
    logic burst_done;
    logic load;

    assign out_ok     = !out_valid_reg || result.ready;
    assign emit       = burst_valid_reg && out_ok;
    assign burst_done = emit && (cnt_reg == ofe_pkg::CNT_W'(1));
    assign burst_free = !burst_valid_reg || burst_done;
    assign load       = load_valid && burst_free && (load_burst.cnt != '0);

    always_comb
    begin
        burst_valid_next = burst_valid_reg;
        bytes_next       = bytes_reg;
        cnt_next         = cnt_reg;
        if (load)
        begin
            burst_valid_next = 1'b1;
            bytes_next       = load_burst.bytes;
            cnt_next         = load_burst.cnt;
        end
        else if (emit)
        begin
            burst_valid_next = !burst_done;
            bytes_next       = bytes_reg >> 8;
            cnt_next         = cnt_reg - ofe_pkg::CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = bytes_reg[0];
            out_last_next  = (cnt_reg == ofe_pkg::CNT_W'(1));
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            burst_valid_reg <= burst_valid_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg    <= bytes_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_last = out_last_reg;

    a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (cnt_reg != '0))
        else $error("burst held with zero byte count");

    a_burst_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid_reg && !out_ok) |=> (burst_valid_reg && $stable(cnt_reg)))
        else $error("burst changed while result stalled");

    a_last_marks_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_last_reg == $past(cnt_reg == ofe_pkg::CNT_W'(1))))
        else $error("out_last does not match end of burst");

endmodule

`default_nettype wire

FILE: rtl/outbound_frame_encapsulator.sv
// outbound_frame_encapsulator: top level; frames payload bytes for TCP or WebSocket.
// Items pass the input register, then the burst register, then the result register.
// Throughput: one item per cycle while each item yields one byte and result.ready holds;
// a multi-byte burst (up to 11 bytes) holds the result register until all are sent.
// Reset (rst_n, async, active low) empties the pipeline and zeroes both config registers.
`timescale 1ns / 1ps
`default_nettype none

module outbound_frame_encapsulator (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ofe_item_if.sink     item,
    ofe_result_if.source result,
    ofe_cfg_if.sink      cfg
);

    ofe_pkg::cfg_t   cfg_state;
    ofe_pkg::burst_t load_burst;
    logic            load_valid;
    logic            burst_free;

    ofe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    ofe_frame_builder u_frame_builder (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_state  (cfg_state),
        .burst_free (burst_free),
        .load_valid (load_valid),
        .load_burst (load_burst)
    );

    ofe_byte_emitter u_byte_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_burst (load_burst),
        .burst_free (burst_free),
        .result     (result)
    );

endmodule

`default_nettype wire
